### hdl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Clocked assertion, switched off while reset is high.
`define RSOS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Clocked assertion that also holds across reset.
`define RSOS_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`endif

### hdl/rsos_pkg.sv
// Shared constants, types and codes of the spin growth move unit.
package rsos_pkg;
   localparam int SITES      = 64;
   localparam int SITE_W     = $clog2(SITES);
   localparam int MAX_HEIGHT = 64;
   localparam int LVL_W      = $clog2(MAX_HEIGHT);
   localparam int HGT_W      = 7;
   localparam int GRID_AW    = SITE_W + LVL_W;
   localparam int GRID_DEPTH = SITES * MAX_HEIGHT;
   localparam int PART_W     = 13;
   localparam int CNT_W      = 32;
   localparam int REG_W      = 16;
   localparam int RND_W      = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int FRAC_W     = 12;
   localparam int QI_W       = 6;
   localparam int C_W        = 20;
   localparam int W_W        = 31;
   localparam int K_W        = 4;
   localparam int TAYLOR_TERMS = 12;

   localparam logic [REG_W-1:0] Q412_ONE   = 16'd4096;
   localparam logic [W_W-1:0]   Q30_ONE    = 31'd1073741824;
   localparam logic [31:0]      EXP_M1_Q32 = 32'd1580030169;

   localparam logic ACT_ADD    = 1'b0;
   localparam logic ACT_REMOVE = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_COUPLING = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CHEM     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PLUS     = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MINUS    = 2'd3;

   typedef struct packed {
      logic load;
      logic hrd0;
      logic hrd1;
      logic hrd2;
      logic srd1;
      logic srd2;
      logic cost;
      logic exp_start;
      logic commit;
   } rsos_cmd_type;

   typedef struct packed {
      logic exp_need;
      logic exp_done;
   } rsos_sts_type;
endpackage

### hdl/rsos_spin_growth_move_unit.sv
// Top level of the spin growth move unit: sequencer, datapath and exponential unit.
//
// Use: raise start with the req_ word (action, site, spin choice, random fraction);
// the word is taken at a rising edge where start is high and busy is low.
// Each move gives one result word on the rsp_ ports, shown for exactly one cycle
// with rsp_valid high; the receiver cannot hold it off and must take it then.
// After accept the sequencer reads the heights, then the spins, forms the cost and
// commits; the exponential runs before the commit only when the move passes the early
// checks and its cost is positive. That unit works through 12 series terms of one
// multiply and one divide each, then one exp(-1) step per integer unit of the Q8.12
// cost taken to six bits (at most 63), cut short once the weight reaches zero.
// Heights and spins sit in memories with two read ports, so the neighbour heights are
// read in two passes and the four spins in two more. One move is in flight at a time;
// busy drops in the cycle the result shows, so the next start can be taken then. The
// user makes csr_ configuration writes only while idle; unchecked, they act at once.
// Reset (synchronous) sets every column to height 1 with a plus spin, the particle
// count to the number of sites and the move count to zero; no clearing pass is needed.
module rsos_spin_growth_move_unit import rsos_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic                 req_action,
   input  logic [SITE_W-1:0]    req_site,
   input  logic                 req_spin_choice,
   input  logic [RND_W-1:0]     req_accept_random,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [REG_W-1:0]     csr_wdata,
   output logic                 rsp_valid,
   output logic                 rsp_accepted,
   output logic signed [1:0]    rsp_charge_change,
   output logic [REG_W-1:0]     rsp_weight_factor,
   output logic [PART_W-1:0]    rsp_particle_total,
   output logic [HGT_W-1:0]     rsp_column_height,
   output logic [CNT_W-1:0]     rsp_move_count,
   output logic                 rsp_height_overflow
);
   rsos_cmd_type      cmd;
   rsos_sts_type      sts;
   logic              exp_need, exp_done;
   logic [FRAC_W-1:0] exp_frac;
   logic [QI_W-1:0]   exp_ipart;
   logic [W_W-1:0]    exp_weight;

   assign sts.exp_need = exp_need;
   assign sts.exp_done = exp_done;

   rsos_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .sts   (sts),
      .busy  (busy),
      .cmd   (cmd)
   );

   rsos_exp u_exp (
      .clock  (clock),
      .reset  (reset),
      .start  (cmd.exp_start),
      .frac   (exp_frac),
      .ipart  (exp_ipart),
      .done   (exp_done),
      .weight (exp_weight)
   );

   rsos_dpath u_dpath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .req_action          (req_action),
      .req_site            (req_site),
      .req_spin_choice     (req_spin_choice),
      .req_accept_random   (req_accept_random),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .exp_weight          (exp_weight),
      .exp_need            (exp_need),
      .exp_frac            (exp_frac),
      .exp_ipart           (exp_ipart),
      .rsp_valid           (rsp_valid),
      .rsp_accepted        (rsp_accepted),
      .rsp_charge_change   (rsp_charge_change),
      .rsp_weight_factor   (rsp_weight_factor),
      .rsp_particle_total  (rsp_particle_total),
      .rsp_column_height   (rsp_column_height),
      .rsp_move_count      (rsp_move_count),
      .rsp_height_overflow (rsp_height_overflow)
   );
endmodule

### hdl/rsos_exp.sv
// Iterative exp(-c) unit: Taylor series on the fraction, exp(-1) steps on the integer part.
module rsos_exp import rsos_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [FRAC_W-1:0] frac,
   input  logic [QI_W-1:0]   ipart,
   output logic              done,
   output logic [W_W-1:0]    weight
);
   localparam logic [2:0] E_IDLE  = 3'd0;
   localparam logic [2:0] E_MUL   = 3'd1;
   localparam logic [2:0] E_DIV   = 3'd2;
   localparam logic [2:0] E_SCALE = 3'd3;
   localparam logic [2:0] E_DONE  = 3'd4;

   logic [2:0]         state_ff, state_in;
   logic [FRAC_W-1:0]  f_ff, f_in;
   logic [QI_W-1:0]    q_ff, q_in;
   logic [W_W-1:0]     term_ff, term_in;
   logic signed [31:0] acc_ff, acc_in;
   logic [K_W-1:0]     k_ff, k_in;
   logic [31:0]        num_ff, num_in;
   logic [K_W:0]       rem_ff, rem_in;
   logic [1:0]         dstep_ff, dstep_in;
   logic [W_W-1:0]     w_ff, w_in;

   logic [W_W+FRAC_W-1:0] prod;
   logic [W_W+31:0]       scaled;
   logic [K_W:0]          r;
   logic [31:0]           n;

   always_comb begin
      prod   = (W_W+FRAC_W)'(term_ff) * (W_W+FRAC_W)'(f_ff);
      scaled = (W_W+32)'(w_ff) * (W_W+32)'(EXP_M1_Q32);
      // restoring divide by k, eight quotient bits a cycle
      r = rem_ff;
      n = num_ff;
      for (int i = 0; i < 8; i++) begin
         r = {r[K_W-1:0], n[31]};
         n = {n[30:0], 1'b0};
         if (r >= {1'b0, k_ff}) begin
            r    = r - {1'b0, k_ff};
            n[0] = 1'b1;
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      f_in     = f_ff;
      q_in     = q_ff;
      term_in  = term_ff;
      acc_in   = acc_ff;
      k_in     = k_ff;
      num_in   = num_ff;
      rem_in   = rem_ff;
      dstep_in = dstep_ff;
      w_in     = w_ff;
      case (state_ff)
         E_IDLE: begin
            if (start) begin
               f_in     = frac;
               q_in     = ipart;
               term_in  = Q30_ONE;
               acc_in   = 32'(Q30_ONE);
               k_in     = K_W'(1);
               state_in = E_MUL;
            end
         end
         E_MUL: begin
            num_in   = 32'(prod[W_W+FRAC_W-2:FRAC_W]);
            rem_in   = '0;
            dstep_in = '0;
            state_in = E_DIV;
         end
         E_DIV: begin
            num_in   = n;
            rem_in   = r;
            dstep_in = dstep_ff + 2'd1;
            if (dstep_ff == 2'd3) begin
               term_in = n[W_W-1:0];
               if (k_ff[0])
                  acc_in = acc_ff - $signed(32'(n[W_W-1:0]));
               else
                  acc_in = acc_ff + $signed(32'(n[W_W-1:0]));
               if (k_ff == K_W'(TAYLOR_TERMS)) begin
                  if (acc_in > 0)
                     w_in = acc_in[W_W-1:0];
                  else
                     w_in = '0;
                  state_in = E_SCALE;
               end else begin
                  k_in     = k_ff + K_W'(1);
                  state_in = E_MUL;
               end
            end
         end
         E_SCALE: begin
            if (q_ff != '0 && w_ff != '0) begin
               w_in = scaled[W_W+31:32];
               q_in = q_ff - QI_W'(1);
            end else begin
               state_in = E_DONE;
            end
         end
         E_DONE: state_in = E_IDLE;
         default: state_in = E_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset)
         state_ff <= E_IDLE;
      else
         state_ff <= state_in;
      f_ff     <= f_in;
      q_ff     <= q_in;
      term_ff  <= term_in;
      acc_ff   <= acc_in;
      k_ff     <= k_in;
      num_ff   <= num_in;
      rem_ff   <= rem_in;
      dstep_ff <= dstep_in;
      w_ff     <= w_in;
   end

   assign done   = (state_ff == E_DONE);
   assign weight = w_ff;
endmodule

### hdl/rsos_ctrl.sv
// Move sequencer: steps the datapath through read, cost, exponential and commit.
module rsos_ctrl import rsos_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  rsos_sts_type sts,
   output logic         busy,
   output rsos_cmd_type cmd
);
   localparam logic [3:0] ST_IDLE     = 4'd0;
   localparam logic [3:0] ST_HRD0     = 4'd1;
   localparam logic [3:0] ST_HRD1     = 4'd2;
   localparam logic [3:0] ST_HRD2     = 4'd3;
   localparam logic [3:0] ST_SRD1     = 4'd4;
   localparam logic [3:0] ST_SRD2     = 4'd5;
   localparam logic [3:0] ST_COST     = 4'd6;
   localparam logic [3:0] ST_BRANCH   = 4'd7;
   localparam logic [3:0] ST_EXP_WAIT = 4'd8;
   localparam logic [3:0] ST_COMMIT   = 4'd9;

   logic [3:0] state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_HRD0;
            end
         end
         ST_HRD0: begin cmd.hrd0 = 1'b1; state_in = ST_HRD1; end
         ST_HRD1: begin cmd.hrd1 = 1'b1; state_in = ST_HRD2; end
         ST_HRD2: begin cmd.hrd2 = 1'b1; state_in = ST_SRD1; end
         ST_SRD1: begin cmd.srd1 = 1'b1; state_in = ST_SRD2; end
         ST_SRD2: begin cmd.srd2 = 1'b1; state_in = ST_COST; end
         ST_COST: begin cmd.cost = 1'b1; state_in = ST_BRANCH; end
         ST_BRANCH: begin
            // skip the exponential when the move is free or already refused
            if (sts.exp_need) begin
               cmd.exp_start = 1'b1;
               state_in      = ST_EXP_WAIT;
            end else begin
               state_in = ST_COMMIT;
            end
         end
         ST_EXP_WAIT: begin
            if (sts.exp_done)
               state_in = ST_COMMIT;
         end
         ST_COMMIT: begin cmd.commit = 1'b1; state_in = ST_IDLE; end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset)
         state_ff <= ST_IDLE;
      else
         state_ff <= state_in;
   end

   assign busy = (state_ff != ST_IDLE);
endmodule

### hdl/rsos_dpath.sv
// Move datapath: surface memories, registers, cost, decision and result word.
module rsos_dpath import rsos_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  rsos_cmd_type            cmd,
   input  logic                    req_action,
   input  logic [SITE_W-1:0]       req_site,
   input  logic                    req_spin_choice,
   input  logic [RND_W-1:0]        req_accept_random,
   input  logic                    csr_we,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [REG_W-1:0]        csr_wdata,
   input  logic [W_W-1:0]          exp_weight,
   output logic                    exp_need,
   output logic [FRAC_W-1:0]       exp_frac,
   output logic [QI_W-1:0]         exp_ipart,
   output logic                    rsp_valid,
   output logic                    rsp_accepted,
   output logic signed [1:0]       rsp_charge_change,
   output logic [REG_W-1:0]        rsp_weight_factor,
   output logic [PART_W-1:0]       rsp_particle_total,
   output logic [HGT_W-1:0]        rsp_column_height,
   output logic [CNT_W-1:0]        rsp_move_count,
   output logic                    rsp_height_overflow
);
   // heights: columns never written read as height 1
   logic [HGT_W-1:0] hmem [SITES];
   logic [SITES-1:0] hvalid_ff;
   // spin grid, 1 means minus; entries above a column's height are never trusted,
   // and level 1 always reads plus, so no clearing is needed
   logic             smem [GRID_DEPTH];

   logic signed [REG_W-1:0] j_ff, mu_ff;
   logic [REG_W-1:0]        wplus_ff, wminus_ff;

   logic                action_ff, choice_ff;
   logic [SITE_W-1:0]   site_ff;
   logic [RND_W-1:0]    rnd_ff;
   logic [CNT_W-1:0]    count_ff;
   logic [PART_W-1:0]   particles_ff;

   logic [HGT_W-1:0]    hra_ff, hrb_ff;
   logic                hva_ff, hvb_ff;
   logic [HGT_W-1:0]    h_ff, hl_ff, hr_ff;
   logic                sra_ff, srb_ff;
   logic signed [1:0]   sl_ff, sr_ff, sb_ff, stop_ff, sp_ff;
   logic signed [C_W-1:0] c_ff;
   logic                ok_ff, ovf_ff, need_ff;

   logic                valid_ff;
   logic                acc_o_ff, ovf_o_ff;
   logic signed [1:0]   dq_o_ff;
   logic [REG_W-1:0]    wf_o_ff;
   logic [HGT_W-1:0]    colh_o_ff;
   logic [CNT_W-1:0]    cnt_o_ff;

   logic [SITE_W-1:0]   left_c, right_c, hb_addr;
   logic [HGT_W-1:0]    ha_eff, hb_eff, ht_c, lvl_top_i, lvl_bel_i, newh_c;
   logic [HGT_W:0]      tgt_c;
   logic [GRID_AW-1:0]  sa_addr, sb_addr, sw_addr;
   logic signed [3:0]   sum_c, ssum_c;
   logic signed [1:0]   sp_c;
   logic signed [C_W-1:0] jprod_c, c_c;
   logic                nbr_ok_c, ovf_c, ok_c, pass_c, acc_c, plus_sel_c, add_c;

   function automatic logic signed [1:0] spin_of(input logic raw,
                                                 input logic [HGT_W-1:0] lvl,
                                                 input logic [HGT_W-1:0] hcol);
      logic signed [1:0] v;
      if (lvl == '0 || lvl > hcol)
         v = 2'sd0;
      else if (lvl == HGT_W'(1))
         v = 2'sd1;
      else
         v = raw ? -2'sd1 : 2'sd1;
      return v;
   endfunction

   always_comb begin
      add_c   = (action_ff == ACT_ADD);
      left_c  = (site_ff == '0) ? SITE_W'(SITES - 1) : site_ff - SITE_W'(1);
      right_c = (site_ff == SITE_W'(SITES - 1)) ? '0 : site_ff + SITE_W'(1);
      hb_addr = cmd.hrd0 ? left_c : right_c;
      ha_eff  = hva_ff ? hra_ff : HGT_W'(1);
      hb_eff  = hvb_ff ? hrb_ff : HGT_W'(1);

      ht_c      = add_c ? h_ff + HGT_W'(1) : h_ff;
      lvl_top_i = ht_c - HGT_W'(1);
      lvl_bel_i = ht_c - HGT_W'(2);
      sa_addr   = cmd.hrd2 ? {left_c, lvl_top_i[LVL_W-1:0]} : {site_ff, lvl_bel_i[LVL_W-1:0]};
      sb_addr   = cmd.hrd2 ? {right_c, lvl_top_i[LVL_W-1:0]} : {site_ff, lvl_top_i[LVL_W-1:0]};
      sw_addr   = {site_ff, lvl_top_i[LVL_W-1:0]};

      // cost of the move in signed Q8.12
      sum_c   = 4'(sl_ff) + 4'(sr_ff) + 4'(sb_ff);
      sp_c    = add_c ? (choice_ff ? -2'sd1 : 2'sd1) : stop_ff;
      ssum_c  = 4'(sp_c) * sum_c;
      jprod_c = C_W'(j_ff) * C_W'(ssum_c);
      c_c     = add_c ? (-jprod_c - C_W'(mu_ff)) : (jprod_c + C_W'(mu_ff));

      tgt_c    = add_c ? {1'b0, h_ff} + (HGT_W+1)'(1) : {1'b0, h_ff} - (HGT_W+1)'(1);
      nbr_ok_c = ({1'b0, hl_ff} <= tgt_c + (HGT_W+1)'(1)) && (tgt_c <= {1'b0, hl_ff} + (HGT_W+1)'(1))
              && ({1'b0, hr_ff} <= tgt_c + (HGT_W+1)'(1)) && (tgt_c <= {1'b0, hr_ff} + (HGT_W+1)'(1));
      ovf_c    = add_c && (ht_c > HGT_W'(MAX_HEIGHT));
      ok_c     = add_c ? (!ovf_c && nbr_ok_c)
                       : ((h_ff > HGT_W'(1)) && (stop_ff != 2'sd0) && nbr_ok_c);

      pass_c     = !need_ff || ({1'b0, rnd_ff, 14'b0} < exp_weight);
      acc_c      = ok_ff && pass_c;
      plus_sel_c = add_c ? (sp_ff == 2'sd1) : (sp_ff == -2'sd1);
      newh_c     = add_c ? ht_c : h_ff - HGT_W'(1);
   end

   // heights memory: two registered read ports, one write port
   always_ff @(posedge clock) begin
      hra_ff <= hmem[site_ff];
      hrb_ff <= hmem[hb_addr];
      if (cmd.commit && acc_c)
         hmem[site_ff] <= newh_c;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hvalid_ff <= '0;
      end else if (cmd.commit && acc_c) begin
         hvalid_ff[site_ff] <= 1'b1;
      end
      hva_ff <= hvalid_ff[site_ff];
      hvb_ff <= hvalid_ff[hb_addr];
   end

   // spin memory: two registered read ports, written only by an accepted add
   always_ff @(posedge clock) begin
      sra_ff <= smem[sa_addr];
      srb_ff <= smem[sb_addr];
      if (cmd.commit && acc_c && add_c)
         smem[sw_addr] <= choice_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         j_ff      <= '0;
         mu_ff     <= '0;
         wplus_ff  <= Q412_ONE;
         wminus_ff <= Q412_ONE;
      end else if (csr_we) begin
         case (csr_index)
            CSR_COUPLING: j_ff      <= $signed(csr_wdata);
            CSR_CHEM:     mu_ff     <= $signed(csr_wdata);
            CSR_PLUS:     wplus_ff  <= csr_wdata;
            CSR_MINUS:    wminus_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         particles_ff <= PART_W'(SITES);
         valid_ff     <= 1'b0;
      end else begin
         valid_ff <= cmd.commit;
         if (cmd.load)
            count_ff <= count_ff + CNT_W'(1);
         if (cmd.commit && acc_c)
            particles_ff <= add_c ? particles_ff + PART_W'(1) : particles_ff - PART_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         action_ff <= req_action;
         site_ff   <= req_site;
         choice_ff <= req_spin_choice;
         rnd_ff    <= req_accept_random;
      end
      if (cmd.hrd1) begin
         h_ff  <= ha_eff;
         hl_ff <= hb_eff;
      end
      if (cmd.hrd2)
         hr_ff <= hb_eff;
      if (cmd.srd1) begin
         sl_ff <= spin_of(sra_ff, ht_c, hl_ff);
         sr_ff <= spin_of(srb_ff, ht_c, hr_ff);
      end
      if (cmd.srd2) begin
         sb_ff   <= spin_of(sra_ff, ht_c - HGT_W'(1), h_ff);
         stop_ff <= spin_of(srb_ff, ht_c, h_ff);
      end
      if (cmd.cost) begin
         c_ff    <= c_c;
         sp_ff   <= sp_c;
         ok_ff   <= ok_c;
         ovf_ff  <= ovf_c;
         need_ff <= ok_c && (c_c > 0);
      end
      if (cmd.commit) begin
         acc_o_ff  <= acc_c;
         dq_o_ff   <= acc_c ? (add_c ? sp_ff : -sp_ff) : 2'sd0;
         wf_o_ff   <= acc_c ? (plus_sel_c ? wplus_ff : wminus_ff) : Q412_ONE;
         colh_o_ff <= acc_c ? newh_c : h_ff;
         cnt_o_ff  <= count_ff;
         ovf_o_ff  <= ovf_ff;
      end
   end

   assign exp_need  = need_ff;
   assign exp_frac  = c_ff[FRAC_W-1:0];
   assign exp_ipart = c_ff[FRAC_W+QI_W-1:FRAC_W];

   assign rsp_valid           = valid_ff;
   assign rsp_accepted        = acc_o_ff;
   assign rsp_charge_change   = dq_o_ff;
   assign rsp_weight_factor   = wf_o_ff;
   assign rsp_particle_total  = particles_ff;
   assign rsp_column_height   = colh_o_ff;
   assign rsp_move_count      = cnt_o_ff;
   assign rsp_height_overflow = ovf_o_ff;
endmodule

### hdl/rsos_checker.sv
// Port-level checks of the move unit, bound to the top level.
`include "assert_macros.svh"
module rsos_checker import rsos_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic              rsp_valid,
   input logic              rsp_accepted,
   input logic signed [1:0] rsp_charge_change,
   input logic [REG_W-1:0]  rsp_weight_factor,
   input logic              rsp_height_overflow
);
   `RSOS_ASSERT(a_start_busy, clock, reset, (start && !busy) |=> busy, "taken word did not raise busy")
   `RSOS_ASSERT(a_single_word, clock, reset, rsp_valid |=> !rsp_valid, "result shown twice")
   `RSOS_ASSERT(a_ovf_refused, clock, reset, (rsp_valid && rsp_height_overflow) |-> !rsp_accepted, "overflow move accepted")
   `RSOS_ASSERT(a_refused_unit, clock, reset, (rsp_valid && !rsp_accepted) |-> (rsp_weight_factor == Q412_ONE && rsp_charge_change == 2'sd0), "refused move changed weight or charge")
   `RSOS_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> (!busy && !rsp_valid), "not idle after reset")
endmodule

bind rsos_spin_growth_move_unit rsos_checker u_rsos_checker (.*);

### bench/tb.sv
// Self-checking testbench of the spin growth move unit.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import rsos_pkg::*;

   typedef struct {
      logic        accepted;
      logic [1:0]  charge;
      logic [15:0] weight;
      logic [12:0] particles;
      logic [6:0]  height;
      logic [31:0] moves;
      logic        overflow;
   } move_result_type;

   // Surface model and queue of pending move results.
   class surface_scoreboard;
      int              col_h[SITES];
      int              spins[SITES][MAX_HEIGHT];
      int              part_count;
      logic [31:0]     move_cnt;
      int              j_coup, mu;
      logic [15:0]     w_plus, w_minus;
      move_result_type pending[$];
      int              errors;

      function void clear();
         foreach (col_h[s]) begin
            col_h[s] = 1;
            foreach (spins[s][l]) spins[s][l] = 0;
            spins[s][0] = 1;
         end
         part_count = SITES;
         move_cnt = '0;
         j_coup = 0;
         mu = 0;
         w_plus = Q412_ONE;
         w_minus = Q412_ONE;
      endfunction

      function void set_reg(logic [1:0] idx, logic [15:0] v);
         case (idx)
            CSR_COUPLING: j_coup = $signed(v);
            CSR_CHEM:     mu = $signed(v);
            CSR_PLUS:     w_plus = v;
            default:      w_minus = v;
         endcase
      endfunction

      function int spin_of(int s, int lvl);
         if (lvl < 1 || lvl > MAX_HEIGHT) return 0;
         return spins[s][lvl-1];
      endfunction

      function bit draw_wins(int c, logic [15:0] rnd);
         longint unsigned f, term, w;
         longint acc;
         int q;
         if (c <= 0) return 1;
         f = 64'(c & 4095);
         q = c >>> 12;
         acc = 64'd1073741824;
         term = 64'd1073741824;
         for (int k = 1; k <= TAYLOR_TERMS; k++) begin
            term = ((term * f) >> 12) / 64'(k);
            if (k % 2) acc -= term;
            else acc += term;
         end
         w = (acc > 0) ? 64'(acc) : 64'd0;
         while (q > 0 && w != 0) begin
            w = (w * 64'd1580030169) >> 32;
            q--;
         end
         return ({48'd0, rnd} << 14) < w;
      endfunction

      function void note_move(logic act, int site, logic choice, logic [15:0] rnd);
         move_result_type r;
         int l, rt, h, hl, hr, ht, sp, sum, c, dq;
         l = (site + SITES - 1) % SITES;
         rt = (site + 1) % SITES;
         h = col_h[site];
         hl = col_h[l];
         hr = col_h[rt];
         dq = 0;
         r.accepted = 1'b0;
         r.overflow = 1'b0;
         r.weight = Q412_ONE;
         move_cnt++;
         if (act == ACT_ADD) begin
            ht = h + 1;
            sp = choice ? -1 : 1;
            if (ht > MAX_HEIGHT) r.overflow = 1'b1;
            else begin
               sum = spin_of(l, ht) + spin_of(rt, ht) + spin_of(site, ht - 1);
               c = -(j_coup * sp * sum) - mu;
               if (draw_wins(c, rnd) && hl - ht <= 1 && ht - hl <= 1
                   && hr - ht <= 1 && ht - hr <= 1) begin
                  spins[site][ht-1] = sp;
                  col_h[site] = ht;
                  part_count = (part_count + 1) & 13'h1fff;
                  dq = sp;
                  r.weight = sp == 1 ? w_plus : w_minus;
                  r.accepted = 1'b1;
               end
            end
         end else if (h > 1) begin
            ht = h;
            sp = spin_of(site, ht);
            sum = spin_of(l, ht) + spin_of(rt, ht) + spin_of(site, ht - 1);
            c = j_coup * sp * sum + mu;
            if (sp != 0 && draw_wins(c, rnd) && hl - ht + 1 <= 1 && ht - 1 - hl <= 1
                && hr - ht + 1 <= 1 && ht - 1 - hr <= 1) begin
               spins[site][ht-1] = 0;
               col_h[site] = ht - 1;
               part_count = (part_count - 1) & 13'h1fff;
               dq = -sp;
               r.weight = sp == -1 ? w_plus : w_minus;
               r.accepted = 1'b1;
            end
         end
         r.charge = dq[1:0];
         r.particles = part_count[12:0];
         r.height = col_h[site][6:0];
         r.moves = move_cnt;
         pending.push_back(r);
      endfunction

      function void check(move_result_type got);
         move_result_type e;
         if (pending.size() == 0) begin
            $error("result word with no move outstanding");
            errors++;
            return;
         end
         e = pending.pop_front();
         if (got.accepted !== e.accepted) begin
            $error("accepted: expected %0d got %0d", e.accepted, got.accepted); errors++;
         end
         if (got.charge !== e.charge) begin
            $error("charge_change: expected %0d got %0d", e.charge, got.charge); errors++;
         end
         if (got.weight !== e.weight) begin
            $error("weight_factor: expected %0d got %0d", e.weight, got.weight); errors++;
         end
         if (got.particles !== e.particles) begin
            $error("particle_total: expected %0d got %0d", e.particles, got.particles);
            errors++;
         end
         if (got.height !== e.height) begin
            $error("column_height: expected %0d got %0d", e.height, got.height); errors++;
         end
         if (got.moves !== e.moves) begin
            $error("move_count: expected %0d got %0d", e.moves, got.moves); errors++;
         end
         if (got.overflow !== e.overflow) begin
            $error("height_overflow: expected %0d got %0d", e.overflow, got.overflow);
            errors++;
         end
      endfunction
   endclass

   logic clock = 0, reset = 1, start = 0, busy;
   logic req_action = 0, req_spin_choice = 0;
   logic [SITE_W-1:0] req_site = 0;
   logic [RND_W-1:0] req_accept_random = 0;
   logic csr_we = 0;
   logic [CSR_IDX_W-1:0] csr_index = 0;
   logic [REG_W-1:0] csr_wdata = 0;
   logic rsp_valid, rsp_accepted, rsp_height_overflow;
   logic signed [1:0] rsp_charge_change;
   logic [REG_W-1:0] rsp_weight_factor;
   logic [PART_W-1:0] rsp_particle_total;
   logic [HGT_W-1:0] rsp_column_height;
   logic [CNT_W-1:0] rsp_move_count;

   surface_scoreboard board = new();
   int gap_pct = 0;
   longint cycles = 0;

   rsos_spin_growth_move_unit dut (.*);

   always begin
      #6 clock = 1;
      #6 clock = 0;
   end

   always @(posedge clock) begin
      move_result_type got;
      cycles++;
      if (cycles > 400000) begin
         $display("*** FAILED ***");
         $finish;
      end
      if (!reset && rsp_valid) begin
         got.accepted = rsp_accepted;
         got.charge = rsp_charge_change;
         got.weight = rsp_weight_factor;
         got.particles = rsp_particle_total;
         got.height = rsp_column_height;
         got.moves = rsp_move_count;
         got.overflow = rsp_height_overflow;
         board.check(got);
      end
   end

   // Hold the word until taken; note it in the model at the accepting edge.
   task automatic send_move(logic act, logic [SITE_W-1:0] site, logic choice,
                            logic [RND_W-1:0] rnd);
      @(negedge clock);
      while ($urandom_range(99) < gap_pct) @(negedge clock);
      start <= 1;
      req_action <= act;
      req_site <= site;
      req_spin_choice <= choice;
      req_accept_random <= rnd;
      do @(posedge clock); while (busy);
      board.note_move(act, int'(site), choice, rnd);
      @(negedge clock);
      start <= 0;
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [REG_W-1:0] v);
      @(negedge clock);
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      board.set_reg(idx, v);
      @(negedge clock);
      csr_we <= 0;
   endtask

   task automatic drain();
      while (board.pending.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic random_moves(int n);
      for (int i = 0; i < n; i++)
         send_move(1'($urandom_range(1)), SITE_W'($urandom_range(SITES - 1)),
                   1'($urandom_range(1)), RND_W'($urandom_range(65535)));
   endtask

   initial begin
      board.clear();
      repeat (7) @(negedge clock);
      reset <= 0;
      @(negedge clock);
      // dearest add: plus spin into a pit between two plus neighbours
      send_move(ACT_ADD, SITE_W'(10), 1'b0, 16'hffff);
      send_move(ACT_ADD, SITE_W'(12), 1'b0, 16'hffff);
      drain();
      write_reg(CSR_COUPLING, 16'h8000);
      write_reg(CSR_CHEM, 16'h8000);
      send_move(ACT_ADD, SITE_W'(11), 1'b0, 16'h0000);
      drain();
      write_reg(CSR_COUPLING, 16'h0000);
      write_reg(CSR_CHEM, 16'h0000);
      // directed: refused remove at height one, adds and removes, extremes
      send_move(ACT_REMOVE, SITE_W'(0), 1'b0, 16'h0000);
      send_move(ACT_ADD, SITE_W'(0), 1'b0, 16'hffff);
      send_move(ACT_ADD, SITE_W'(63), 1'b1, 16'h0000);
      send_move(ACT_ADD, SITE_W'(1), 1'b1, 16'h8000);
      send_move(ACT_REMOVE, SITE_W'(63), 1'b0, 16'hffff);
      send_move(ACT_REMOVE, SITE_W'(0), 1'b1, 16'h0001);
      // two layers over the whole ring, plus spins in the first and minus spins in the second
      for (int lvl = 0; lvl < 2; lvl++)
         for (int s = 0; s < SITES; s++)
            send_move(ACT_ADD, SITE_W'(s), 1'(lvl % 2), 16'h0000);
      drain();
      write_reg(CSR_COUPLING, 16'h7fff);
      write_reg(CSR_CHEM, 16'h8000);
      write_reg(CSR_PLUS, 16'hffff);
      write_reg(CSR_MINUS, 16'h0000);
      gap_pct = 22;
      random_moves(100);
      drain();
      write_reg(CSR_COUPLING, 16'h8000);
      write_reg(CSR_CHEM, 16'h7fff);
      write_reg(CSR_PLUS, 16'h1234);
      write_reg(CSR_MINUS, 16'hfedc);
      gap_pct = 50;
      random_moves(100);
      drain();
      // mild positive costs: exercise the exponential's fraction and integer parts
      write_reg(CSR_COUPLING, 16'h0600);
      write_reg(CSR_CHEM, 16'hfc00);
      gap_pct = 0;
      random_moves(100);
      drain();
      // strong growth: every add passes the random test
      write_reg(CSR_COUPLING, 16'h0000);
      write_reg(CSR_CHEM, 16'h7fff);
      for (int i = 0; i < 40; i++)
         send_move(ACT_ADD, SITE_W'($urandom_range(SITES - 1)), 1'($urandom_range(1)),
                   RND_W'($urandom_range(65535)));
      drain();
      write_reg(CSR_CHEM, 16'h0000);
      random_moves(30);
      drain();
      if (board.errors == 0) $display("*** PASSED ***");
      else $display("*** FAILED ***");
      $finish;
   end
endmodule
